@@ rtl/rate_monotonic_tick_scheduler_core_assert.svh @@
// assertion macros for the tick scheduler checker
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_CORE_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define RMTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define RMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rmts_pkg.sv @@
`timescale 1ns / 1ps

package rmts_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int TIME_BITS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int SLOT_F_W = 3;
    localparam int LABEL_W  = 8;
    localparam int TICK_W   = 16;
    localparam int TC_W     = 4;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_LEN  = 1'd1;

    typedef struct packed {
        logic load;
        logic start;
        logic update;
    } t_store_ctl;

endpackage

@@ rtl/rmts_slot_store.sv @@
`timescale 1ns / 1ps

module rmts_slot_store #(
    parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = rmts_pkg::TIME_BITS_DEF,
    parameter int SLOT_W    = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rmts_pkg::t_store_ctl         i_ctl,
    input  logic [SLOT_W-1:0]            i_load_slot,
    input  logic [TIME_BITS-1:0]         i_load_exec,
    input  logic [TIME_BITS-1:0]         i_load_period,
    input  logic [rmts_pkg::LABEL_W-1:0] i_load_label,
    input  logic [SLOT_W-1:0]            i_idx,
    input  logic [TIME_BITS+3:0]         i_upd_rem,
    input  logic [TIME_BITS-1:0]         i_upd_cd,
    output logic [TIME_BITS-1:0]         o_exec,
    output logic [TIME_BITS-1:0]         o_period,
    output logic [rmts_pkg::LABEL_W-1:0] o_label,
    output logic [TIME_BITS+3:0]         o_rem,
    output logic [TIME_BITS-1:0]         o_cd
);
    import rmts_pkg::*;

    localparam int REM_W = TIME_BITS + 4;

    logic [TIME_BITS-1:0] r_exec   [MAX_TASKS];
    logic [TIME_BITS-1:0] r_period [MAX_TASKS];
    logic [LABEL_W-1:0]   r_label  [MAX_TASKS];
    logic [REM_W-1:0]     r_rem    [MAX_TASKS];
    logic [TIME_BITS-1:0] r_cd     [MAX_TASKS];

    // task parameters, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_exec[i_load_slot]   <= i_load_exec;
            r_period[i_load_slot] <= i_load_period;
            r_label[i_load_slot]  <= i_load_label;
        end
    end

    // per-slot run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_rem[k] <= '0;
                r_cd[k]  <= '0;
            end
        end else if (i_ctl.start) begin
            r_rem[i_idx] <= {4'b0, r_exec[i_idx]};
            r_cd[i_idx]  <= r_period[i_idx];
        end else if (i_ctl.update) begin
            r_rem[i_idx] <= i_upd_rem;
            r_cd[i_idx]  <= i_upd_cd;
        end
    end

    assign o_exec   = r_exec[i_idx];
    assign o_period = r_period[i_idx];
    assign o_label  = r_label[i_idx];
    assign o_rem    = r_rem[i_idx];
    assign o_cd     = r_cd[i_idx];

endmodule

@@ rtl/rmts_step_unit.sv @@
`timescale 1ns / 1ps

module rmts_step_unit #(
    parameter int TIME_BITS = rmts_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS+3:0]         i_rem,
    input  logic [TIME_BITS-1:0]         i_exec,
    input  logic [TIME_BITS-1:0]         i_period,
    input  logic [rmts_pkg::LABEL_W-1:0] i_label,
    input  logic [TIME_BITS-1:0]         i_cd,
    input  logic                         i_have_best,
    input  logic [TIME_BITS-1:0]         i_best_period,
    input  logic [rmts_pkg::LABEL_W-1:0] i_best_label,
    input  logic                         i_is_best,
    output logic                         o_better,
    output logic [TIME_BITS+3:0]         o_rem,
    output logic [TIME_BITS-1:0]         o_cd,
    output logic                         o_ovf
);
    import rmts_pkg::*;

    localparam int REM_W = TIME_BITS + 4;
    localparam int SUM_W = REM_W + 1;

    logic [REM_W-1:0] w_rem_dec;
    logic [SUM_W-1:0] w_sum;
    logic             w_release;
    logic             w_sat;

    // priority compare: shorter period, then smaller label
    assign o_better = (i_rem != '0) &&
                      (!i_have_best || (i_period < i_best_period) ||
                       ((i_period == i_best_period) && (i_label < i_best_label)));

    // run one unit, then release a new job
    assign w_rem_dec = i_rem - REM_W'(i_is_best);
    assign w_sum     = {1'b0, w_rem_dec} + SUM_W'(i_exec);
    assign w_sat     = w_sum[REM_W];
    assign w_release = (i_cd[TIME_BITS-1:1] == '0);

    assign o_rem = w_release ? (w_sat ? {REM_W{1'b1}} : w_sum[REM_W-1:0]) : w_rem_dec;
    assign o_cd  = w_release ? i_period : (i_cd - TIME_BITS'(1));
    assign o_ovf = w_release && w_sat;

endmodule

@@ rtl/rate_monotonic_tick_scheduler_core.sv @@
`timescale 1ns / 1ps
// Rate-monotonic tick scheduler.
// Input words (valid/ready): cmd selects load of a task slot (slot, exec_time,
// job period, task_label), start of the schedule, or one time tick.
// Each accepted word gives exactly one output word (valid/ready).
// A tick reports the slot and label that ran, or idle, plus the tick number,
// the schedule end flag and a saturation flag; other words report idle.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 task count,
// 1 schedule length); the user must write only while no word is in flight (not enforced).
// One compare/update unit walks the slots: a scan pass over the active slots
// picks the winner, then a release pass runs it and releases jobs. One word is
// worked at a time; the next is taken the cycle after the result is registered.
// The output register holds a finished result while the receiver stalls;
// processing of a new word finishes and then waits until it is free.
// Reset clears the run state, the tick counter and the output valid flag,
// and sets the task count and schedule length to one.
module rate_monotonic_tick_scheduler_core #(
    parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = rmts_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rmts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rmts_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rmts_pkg::CMD_W-1:0]     i_cmd,
    input  logic [rmts_pkg::SLOT_F_W-1:0]  i_slot,
    input  logic [TIME_BITS-1:0]           i_exec_time,
    input  logic [TIME_BITS-1:0]           i_job_period,
    input  logic [rmts_pkg::LABEL_W-1:0]   i_task_label,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rmts_pkg::SLOT_F_W-1:0]  o_ran_slot,
    output logic [rmts_pkg::LABEL_W-1:0]   o_ran_label,
    output logic                           o_idle,
    output logic [rmts_pkg::TICK_W-1:0]    o_tick_number,
    output logic                           o_schedule_end,
    output logic                           o_overflow
);
    import rmts_pkg::*;

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int REM_W  = TIME_BITS + 4;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_REL   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [CMD_W-1:0]     r_cmd;
    logic [SLOT_W-1:0]    r_idx;
    logic [CNT_W-1:0]     r_n;
    logic                 r_have_best;
    logic [SLOT_W-1:0]    r_best_idx;
    logic [TIME_BITS-1:0] r_best_period;
    logic [LABEL_W-1:0]   r_best_label;
    logic                 r_ovf;
    logic [TIME_BITS-1:0] r_tick;
    logic [TC_W-1:0]      r_task_count;
    logic [TICK_W-1:0]    r_sched_len;

    logic                 r_out_valid;
    logic [SLOT_F_W-1:0]  r_ran_slot;
    logic [LABEL_W-1:0]   r_ran_label;
    logic                 r_idle;
    logic [TICK_W-1:0]    r_tick_number;
    logic                 r_sched_end;
    logic                 r_overflow;

    logic                 w_accept;
    logic                 w_last;
    logic                 w_out_free;
    logic [CNT_W-1:0]     w_n;
    logic [SLOT_W+SLOT_F_W-1:0] w_load_ext;
    logic [SLOT_W+SLOT_F_W-1:0] w_best_ext;
    logic [TIME_BITS+TICK_W-1:0] w_tick_ext;
    logic [TIME_BITS+TICK_W-1:0] w_len_ext;
    t_store_ctl           w_ctl;

    logic [TIME_BITS-1:0] w_rd_exec;
    logic [TIME_BITS-1:0] w_rd_period;
    logic [LABEL_W-1:0]   w_rd_label;
    logic [REM_W-1:0]     w_rd_rem;
    logic [TIME_BITS-1:0] w_rd_cd;
    logic                 w_better;
    logic [REM_W-1:0]     w_upd_rem;
    logic [TIME_BITS-1:0] w_upd_cd;
    logic                 w_upd_ovf;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_n);
    assign w_n        = (32'(r_task_count) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                        : CNT_W'(r_task_count);
    assign w_load_ext = {{SLOT_W{1'b0}}, i_slot};
    assign w_best_ext = {{SLOT_F_W{1'b0}}, r_best_idx};
    assign w_tick_ext = {{TICK_W{1'b0}}, r_tick};
    assign w_len_ext  = {{TIME_BITS{1'b0}}, r_sched_len};

    always_comb begin
        w_ctl.load   = w_accept && (i_cmd == CMD_LOAD) && (32'(i_slot) < MAX_TASKS);
        w_ctl.start  = (r_state == S_START);
        w_ctl.update = (r_state == S_REL);
    end

    rmts_slot_store #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS),
        .SLOT_W    (SLOT_W)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_load_slot   (w_load_ext[SLOT_W-1:0]),
        .i_load_exec   (i_exec_time),
        .i_load_period (i_job_period),
        .i_load_label  (i_task_label),
        .i_idx         (r_idx),
        .i_upd_rem     (w_upd_rem),
        .i_upd_cd      (w_upd_cd),
        .o_exec        (w_rd_exec),
        .o_period      (w_rd_period),
        .o_label       (w_rd_label),
        .o_rem         (w_rd_rem),
        .o_cd          (w_rd_cd)
    );

    rmts_step_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_rem         (w_rd_rem),
        .i_exec        (w_rd_exec),
        .i_period      (w_rd_period),
        .i_label       (w_rd_label),
        .i_cd          (w_rd_cd),
        .i_have_best   (r_have_best),
        .i_best_period (r_best_period),
        .i_best_label  (r_best_label),
        .i_is_best     (r_have_best && (r_idx == r_best_idx)),
        .o_better      (w_better),
        .o_rem         (w_upd_rem),
        .o_cd          (w_upd_cd),
        .o_ovf         (w_upd_ovf)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_cmd == CMD_START) && (w_n != '0)) begin
                        n_state = S_START;
                    end else if ((i_cmd == CMD_TICK) && (w_n != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_START: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_REL;
                end
            end
            S_REL: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer and slot walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= CMD_LOAD;
            r_idx       <= '0;
            r_n         <= '0;
            r_have_best <= 1'b0;
            r_ovf       <= 1'b0;
            r_tick      <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd       <= i_cmd;
                        r_idx       <= '0;
                        r_n         <= w_n;
                        r_have_best <= 1'b0;
                        r_ovf       <= 1'b0;
                        if (i_cmd == CMD_START) begin
                            r_tick <= '0;
                        end else if (i_cmd == CMD_TICK) begin
                            r_tick <= r_tick + TIME_BITS'(1);
                        end
                    end
                end
                S_START: begin
                    r_idx <= r_idx + SLOT_W'(1);
                end
                S_SCAN: begin
                    if (w_better) begin
                        r_have_best <= 1'b1;
                    end
                    r_idx <= w_last ? '0 : (r_idx + SLOT_W'(1));
                end
                S_REL: begin
                    r_ovf <= r_ovf | w_upd_ovf;
                    r_idx <= r_idx + SLOT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // current winner
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && w_better) begin
            r_best_idx    <= r_idx;
            r_best_period <= w_rd_period;
            r_best_label  <= w_rd_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TC_W'(1);
            r_sched_len  <= TICK_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TASK_COUNT: r_task_count <= i_cfg_data[TC_W-1:0];
                CFG_SCHED_LEN:  r_sched_len  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            if (r_cmd == CMD_TICK) begin
                r_ran_slot    <= r_have_best ? w_best_ext[SLOT_F_W-1:0] : '0;
                r_ran_label   <= r_have_best ? r_best_label : '0;
                r_idle        <= !r_have_best;
                r_tick_number <= w_tick_ext[TICK_W-1:0];
                r_sched_end   <= (w_tick_ext == w_len_ext);
                r_overflow    <= r_ovf;
            end else begin
                r_ran_slot    <= '0;
                r_ran_label   <= '0;
                r_idle        <= 1'b1;
                r_tick_number <= '0;
                r_sched_end   <= 1'b0;
                r_overflow    <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ran_slot     = r_ran_slot;
    assign o_ran_label    = r_ran_label;
    assign o_idle         = r_idle;
    assign o_tick_number  = r_tick_number;
    assign o_schedule_end = r_sched_end;
    assign o_overflow     = r_overflow;

endmodule

@@ rtl/rmts_checker.sv @@
`timescale 1ns / 1ps
`include "rate_monotonic_tick_scheduler_core_assert.svh"

module rmts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_idle,
    input logic [rmts_pkg::SLOT_F_W-1:0] o_ran_slot,
    input logic [rmts_pkg::LABEL_W-1:0]  o_ran_label
);
    import rmts_pkg::*;

    // stalled result word holds
    `RMTS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_ran_slot) && $stable(o_ran_label) && $stable(o_idle),
        "result word changed while stalled")

    // idle result carries no task
    `RMTS_ASSERT_NOW(a_idle_clean, o_out_valid && o_idle,
        (o_ran_slot == '0) && (o_ran_label == '0), "idle result names a task")

    // nothing pending right after reset
    `RMTS_ASSERT_NOW(a_rst_empty, $past(!i_rst_n), !o_out_valid,
        "result word valid after reset")

    // one word in flight at a time
    `RMTS_ASSERT_NEXT(a_busy, i_in_valid && o_in_ready, !o_in_ready,
        "input taken while a word is in progress")

endmodule

bind rate_monotonic_tick_scheduler_core rmts_checker u_rmts_checker (.*);
